@@ sv/aac_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// aac_pkg
// Shared widths, codes and types of the accelerometer activity classifier.
// ----------------------------------------------------------------------------
package aac_pkg;

  localparam int ACCEL_BITS = 16;             // axis bits taken from each field
  localparam int TIME_BITS  = 32;             // timestamp bits taken from now_ms

  localparam int FIELD_W    = 16;             // packed width of one axis field
  localparam int NOW_W      = 32;             // packed width of now_ms
  localparam int SUM_W      = 2 * ACCEL_BITS; // three squares stay below 2^SUM_W
  localparam int MAG_W      = 16;
  localparam int STEP_W     = 32;
  localparam int THR_W      = 16;
  localparam int WIN_W      = 32;
  localparam int INC_W      = 8;
  localparam int CMP_W      = (TIME_BITS > WIN_W) ? TIME_BITS : WIN_W;

  localparam int IN_DATA_W  = 80;             // 3 x 16 + 32
  localparam int OUT_DATA_W = 56;             // 3 + 32 + 16 + 1, padded to bytes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_MOVE_THR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WALK_THR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_THR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_WIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STILL_WIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WALK_INC  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_INC   = 3'd6;

  typedef enum logic [2:0] {
    ACT_SITTING = 3'd0,
    ACT_STILL   = 3'd1,
    ACT_MOVING  = 3'd2,
    ACT_WALKING = 3'd3,
    ACT_RUNNING = 3'd4
  } activity_t;

  typedef struct packed {
    logic [THR_W-1:0] move_threshold;
    logic [THR_W-1:0] walk_threshold;
    logic [THR_W-1:0] run_threshold;
    logic [WIN_W-1:0] active_window_ms;
    logic [WIN_W-1:0] still_window_ms;
    logic [INC_W-1:0] walk_step_increment;
    logic [INC_W-1:0] run_step_increment;
  } cfg_t;

  typedef struct packed {
    activity_t         activity;
    logic [STEP_W-1:0] step_count;
    logic [MAG_W-1:0]  magnitude;
    logic              moved;
  } res_t;

endpackage
`default_nettype wire

@@ sv/aac_sumsq.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// aac_sumsq
// Sum of squared axes, one shared multiplier used once per axis.
// ----------------------------------------------------------------------------
module aac_sumsq (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [aac_pkg::ACCEL_BITS-1:0] ax,
  input  wire logic [aac_pkg::ACCEL_BITS-1:0] ay,
  input  wire logic [aac_pkg::ACCEL_BITS-1:0] az,
  output logic                                done,
  output logic [aac_pkg::SUM_W-1:0]           sum
);
  import aac_pkg::*;

  logic [ACCEL_BITS-1:0] axis_q [3];
  logic [ACCEL_BITS-1:0] abs_val;
  logic [SUM_W-1:0]      prod;
  logic                  prod_valid;
  logic [1:0]            issued;
  logic                  busy;

  // Two's complement magnitude; the most negative code maps to 2^(ACCEL_BITS-1).
  assign abs_val = axis_q[0][ACCEL_BITS-1] ? (~axis_q[0] + 1'b1) : axis_q[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      prod_valid <= 1'b0;
      issued     <= 2'd0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        axis_q[0]  <= ax;
        axis_q[1]  <= ay;
        axis_q[2]  <= az;
        busy       <= 1'b1;
        issued     <= 2'd0;
        prod_valid <= 1'b0;
        sum        <= '0;
      end else if (busy) begin
        if (issued != 2'd3) begin
          prod       <= SUM_W'(abs_val) * SUM_W'(abs_val);
          prod_valid <= 1'b1;
          axis_q[0]  <= axis_q[1];
          axis_q[1]  <= axis_q[2];
          issued     <= issued + 2'd1;
        end else begin
          prod_valid <= 1'b0;
        end
        if (prod_valid) begin
          sum <= sum + prod;
          // last product lands: finish
          if (issued == 2'd3) begin
            done <= 1'b1;
            busy <= 1'b0;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/aac_isqrt.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// aac_isqrt
// Floored integer square root, one result bit per cycle through a shared
// subtract and compare.
// ----------------------------------------------------------------------------
module aac_isqrt (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [aac_pkg::SUM_W-1:0]     radicand,
  output logic                               done,
  output logic [aac_pkg::ACCEL_BITS-1:0]     root
);
  import aac_pkg::*;

  localparam int CNT_W = $clog2(ACCEL_BITS);
  localparam int REM_W = ACCEL_BITS + 2;

  logic [SUM_W-1:0] src;
  logic [REM_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [REM_W+1:0] rem_sh;
  logic [REM_W+1:0] trial;
  logic [REM_W+1:0] diff;
  logic             fits;

  // Bring down the next two radicand bits and try root*4+1.
  assign rem_sh = {rem, src[SUM_W-1 -: 2]};
  assign trial  = {2'b00, root, 2'b01};
  assign fits   = (rem_sh >= trial);
  assign diff   = rem_sh - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(ACCEL_BITS - 1);
        src  <= radicand;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        src  <= {src[SUM_W-3:0], 2'b00};
        rem  <= fits ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
        root <= {root[ACCEL_BITS-2:0], fits};
        cnt  <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/aac_track.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// aac_track
// Movement, step and activity tracking state, updated once per sample.
// ----------------------------------------------------------------------------
module aac_track (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire aac_pkg::cfg_t                 cfg,
  input  wire logic                          update,
  input  wire logic [aac_pkg::MAG_W-1:0]     mag,
  input  wire logic [aac_pkg::TIME_BITS-1:0] now,
  output aac_pkg::res_t                      res
);
  import aac_pkg::*;

  logic [MAG_W-1:0]     last_magnitude;
  logic [TIME_BITS-1:0] last_movement_ms;
  logic [STEP_W-1:0]    step_total;
  activity_t            previous_activity;

  logic [MAG_W-1:0]     delta;
  logic                 moved;
  logic [TIME_BITS-1:0] last_movement_ms_next;
  logic [TIME_BITS-1:0] elapsed;
  logic [CMP_W-1:0]     elapsed_ext;
  logic [STEP_W-1:0]    step_total_next;
  activity_t            activity_next;

  always_comb begin
    delta = (mag > last_magnitude) ? (mag - last_magnitude) : (last_magnitude - mag);
    moved = (delta > cfg.move_threshold);
    last_movement_ms_next = moved ? now : last_movement_ms;
    elapsed     = now - last_movement_ms_next;
    elapsed_ext = CMP_W'(elapsed);

    // increment follows the class of the previous sample
    case (previous_activity)
      ACT_WALKING: step_total_next = step_total + STEP_W'(cfg.walk_step_increment);
      ACT_RUNNING: step_total_next = step_total + STEP_W'(cfg.run_step_increment);
      default:     step_total_next = step_total;
    endcase

    if (elapsed_ext < CMP_W'(cfg.active_window_ms)) begin
      if (mag > cfg.run_threshold) begin
        activity_next = ACT_RUNNING;
      end else if (mag > cfg.walk_threshold) begin
        activity_next = ACT_WALKING;
      end else begin
        activity_next = ACT_MOVING;
      end
    end else if (elapsed_ext < CMP_W'(cfg.still_window_ms)) begin
      activity_next = ACT_STILL;
    end else begin
      activity_next = ACT_SITTING;
    end

    res.activity   = activity_next;
    res.step_count = step_total_next;
    res.magnitude  = mag;
    res.moved      = moved;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_magnitude    <= '0;
      last_movement_ms  <= '0;
      step_total        <= '0;
      previous_activity <= ACT_SITTING;
    end else if (update) begin
      last_magnitude    <= mag;
      last_movement_ms  <= last_movement_ms_next;
      step_total        <= step_total_next;
      previous_activity <= activity_next;
    end
  end

endmodule
`default_nettype wire

@@ sv/accel_activity_classifier.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// accel_activity_classifier
// Activity classifier and step estimator for three-axis accelerometer samples.
// ----------------------------------------------------------------------------
// Each accepted item holds three raw axes and a millisecond timestamp; the
// block returns one item with the activity class, the running step total, the
// floored magnitude sqrt(x^2+y^2+z^2) and the movement flag. An accepted item
// passes through three phases: the squares, which pass one at a time through
// a single multiplier and accumulator, the square root, which resolves one
// bit per cycle, and the tracking update. Input ready is high only while the
// sequencer is idle, so a new item is taken only once the last result has
// been registered for the output; a result still waiting on the output holds
// the update.
// Configuration writes go through cfg_we/cfg_index/cfg_wdata and take effect
// at once; write them only while no item is in flight.
// ----------------------------------------------------------------------------
module accel_activity_classifier (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // accel_x[15:0], accel_y[31:16], accel_z[47:32], now_ms[79:48]
  input  wire logic [aac_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // activity[2:0], step_count[34:3], magnitude[50:35], moved[51], zero[55:52]
  output logic [aac_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
  input  wire logic                             cfg_we,
  input  wire logic [aac_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [aac_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import aac_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    SQUARE,
    ROOT,
    UPDATE
  } state_t;

  state_t               state;
  cfg_t                 cfg;
  logic [TIME_BITS-1:0] now_q;

  logic                  accept;
  logic                  sq_done;
  logic [SUM_W-1:0]      sq_sum;
  logic                  rt_done;
  logic [ACCEL_BITS-1:0] rt_root;
  logic                  trk_update;
  res_t                  trk_res;

  assign s_axis_tready = (state == IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign trk_update    = (state == UPDATE) && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.move_threshold      <= 16'd819;
      cfg.walk_threshold      <= 16'd19661;
      cfg.run_threshold       <= 16'd24576;
      cfg.active_window_ms    <= 32'd1000;
      cfg.still_window_ms     <= 32'd30000;
      cfg.walk_step_increment <= 8'd2;
      cfg.run_step_increment  <= 8'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MOVE_THR:   cfg.move_threshold      <= cfg_wdata[THR_W-1:0];
        REG_WALK_THR:   cfg.walk_threshold      <= cfg_wdata[THR_W-1:0];
        REG_RUN_THR:    cfg.run_threshold       <= cfg_wdata[THR_W-1:0];
        REG_ACTIVE_WIN: cfg.active_window_ms    <= cfg_wdata[WIN_W-1:0];
        REG_STILL_WIN:  cfg.still_window_ms     <= cfg_wdata[WIN_W-1:0];
        REG_WALK_INC:   cfg.walk_step_increment <= cfg_wdata[INC_W-1:0];
        REG_RUN_INC:    cfg.run_step_increment  <= cfg_wdata[INC_W-1:0];
        default: ;
      endcase
    end
  end

  aac_sumsq u_sumsq (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .ax    (ACCEL_BITS'(s_axis_tdata[FIELD_W-1:0])),
    .ay    (ACCEL_BITS'(s_axis_tdata[2*FIELD_W-1:FIELD_W])),
    .az    (ACCEL_BITS'(s_axis_tdata[3*FIELD_W-1:2*FIELD_W])),
    .done  (sq_done),
    .sum   (sq_sum)
  );

  aac_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_done),
    .radicand (sq_sum),
    .done     (rt_done),
    .root     (rt_root)
  );

  aac_track u_track (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .update (trk_update),
    .mag    (MAG_W'(rt_root)),
    .now    (now_q),
    .res    (trk_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && !trk_update) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (accept) begin
            now_q <= TIME_BITS'(s_axis_tdata[3*FIELD_W+NOW_W-1:3*FIELD_W]);
            state <= SQUARE;
          end
        end
        SQUARE: begin
          if (sq_done) begin
            state <= ROOT;
          end
        end
        ROOT: begin
          if (rt_done) begin
            state <= UPDATE;
          end
        end
        UPDATE: begin
          // hold until the output slot is free
          if (trk_update) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {4'b0000, trk_res.moved, trk_res.magnitude,
                              trk_res.step_count, trk_res.activity};
            state         <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_axis_tready)
    else $error("input ready while an item is in flight");

  a_sq_done_in_square: assert property (@(posedge clk) disable iff (rst)
    sq_done |-> (state == SQUARE))
    else $error("sum of squares finished outside the square phase");

  a_rt_done_in_root: assert property (@(posedge clk) disable iff (rst)
    rt_done |-> (state == ROOT))
    else $error("square root finished outside the root phase");

  a_update_presents: assert property (@(posedge clk) disable iff (rst)
    trk_update |=> (m_axis_tvalid && (m_axis_tdata[2:0] <= ACT_RUNNING)))
    else $error("tracking update did not present a valid result item");

endmodule
`default_nettype wire
